// File: design/owrse_pkg.sv
// Package for the 1-Wire SEARCH ROM decision core: field widths, codes,
// stream packing constants and the Dallas CRC-8 byte update.
// Depends on nothing; imported by one_wire_rom_search_engine, owrse_search_checker and the testbench.
`default_nettype none

package owrse_pkg;

  // Operation codes carried on s_tuser
  localparam logic OP_START = 1'b0;
  localparam logic OP_BIT   = 1'b1;

  // Result status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_MORE     = 2'd1;
  localparam logic [1:0] STATUS_BOTH_ONE = 2'd2;
  localparam logic [1:0] STATUS_CRC_BAD  = 2'd3;

  // Field widths
  localparam int MASK_W   = 8;
  localparam int BYTE_W   = 8;
  localparam int INDEX_W  = 3;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 6;

  // Index of the byte that carries the CRC
  localparam logic [INDEX_W-1:0] LAST_BYTE = 3'd7;
  // Bit position within a byte of its final bit
  localparam logic [2:0] BYTE_LAST_BIT = 3'd7;

  // Reflected CRC-8 polynomial (x^8 + x^5 + x^4 + 1)
  localparam logic [7:0] CRC_POLY = 8'h8C;

  // Stream data widths, padded to whole bytes
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;

  // One CRC-8 update over a byte, LSB first
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                           input logic [7:0] data_in);
    logic [7:0] crc;
    logic [7:0] data;
    logic       mix;
    crc  = crc_in;
    data = data_in;
    for (int k = 0; k < BYTE_W; k++) begin
      mix  = crc[0] ^ data[0];
      crc  = crc >> 1;
      if (mix) begin
        crc = crc ^ CRC_POLY;
      end
      data = data >> 1;
    end
    return crc;
  endfunction

endpackage

`default_nettype wire

// File: design/one_wire_rom_search_engine.sv
// Top level of the 1-Wire SEARCH ROM decision core with CRC-8 check.
// Depends on owrse_pkg (codes, widths, crc8_byte).
//
// Accepts one item per cycle while s_tready is high. A start item (s_tuser = 0)
// loads the branch mask and opens a search; it gives no result. Each bit-pair
// item during a search gives exactly one result, in the next cycle, in the
// output register: the direction bit to write back, and on every eighth bit
// the completed ID byte. The 64th bit, or a pair of two ones, closes the
// search with m_tlast set and the final status. Bit pairs while idle are
// dropped. A single output register sets the rate: s_tready stays high while
// that register is empty or being taken, so the sustained rate is one item
// per cycle; the CRC update is an 8-step combinational pass over one byte.
`default_nettype none

module one_wire_rom_search_engine (
  input  wire                             clk,
  input  wire                             rst,
  // Input stream
  input  wire                             s_tvalid,
  output logic                            s_tready,
  // s_tdata: [7:0] branch_mask, [8] id_bit, [9] complement_bit, [15:10] zero
  input  wire  [owrse_pkg::IN_DATA_W-1:0] s_tdata,
  // s_tuser: [0] operation
  input  wire                             s_tuser,
  // Result stream
  output logic                            m_tvalid,
  input  wire                             m_tready,
  // m_tdata: [0] direction_bit, [1] byte_valid, [4:2] byte_index,
  //          [12:5] id_byte, [14:13] status, [15] zero
  output logic [owrse_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                            m_tlast
);

  import owrse_pkg::*;

  // Search state
  logic [MASK_W-1:0]  mask_shift, mask_shift_next;
  logic [COUNT_W-1:0] bit_count, bit_count_next;
  logic [BYTE_W-1:0]  byte_shift, byte_shift_next;
  logic [BYTE_W-1:0]  crc_reg, crc_reg_next;
  logic               more_flag, more_flag_next;
  logic               active, active_next;

  // Input fields
  logic              in_op;
  logic [MASK_W-1:0] in_mask;
  logic              in_id;
  logic              in_comp;
  logic              s_accept;

  // Result of the current item
  logic                has_result;
  logic                res_dir;
  logic                res_byte_valid;
  logic [INDEX_W-1:0]  res_index;
  logic [BYTE_W-1:0]   res_byte;
  logic                res_last;
  logic [STATUS_W-1:0] res_status;
  logic [BYTE_W-1:0]   shifted;

  assign in_op    = s_tuser;
  assign in_mask  = s_tdata[MASK_W-1:0];
  assign in_id    = s_tdata[MASK_W];
  assign in_comp  = s_tdata[MASK_W+1];

  assign s_tready = !m_tvalid || m_tready;
  assign s_accept = s_tvalid && s_tready;

  // Per-item decision logic
  always_comb begin
    mask_shift_next = mask_shift;
    bit_count_next  = bit_count;
    byte_shift_next = byte_shift;
    crc_reg_next    = crc_reg;
    more_flag_next  = more_flag;
    active_next     = active;
    has_result      = 1'b0;
    res_dir         = 1'b0;
    res_byte_valid  = 1'b0;
    res_index       = '0;
    res_byte        = '0;
    res_last        = 1'b0;
    res_status      = STATUS_OK;
    shifted         = byte_shift;
    if (s_accept) begin
      if (in_op == OP_START) begin
        mask_shift_next = in_mask;
        bit_count_next  = '0;
        byte_shift_next = '0;
        crc_reg_next    = '0;
        more_flag_next  = 1'b0;
        active_next     = 1'b1;
      end else if (active) begin
        has_result = 1'b1;
        if (in_id && in_comp) begin
          // no device answered: abort
          res_last    = 1'b1;
          res_status  = STATUS_BOTH_ONE;
          active_next = 1'b0;
        end else begin
          if (in_id != in_comp) begin
            res_dir = in_id;
          end else begin
            // discrepancy: take next mask bit
            res_dir         = mask_shift[0];
            mask_shift_next = mask_shift >> 1;
            if (!mask_shift[0]) begin
              more_flag_next = 1'b1;
            end
          end
          shifted        = {res_dir, byte_shift[BYTE_W-1:1]};
          bit_count_next = bit_count + COUNT_W'(1);
          if (bit_count[2:0] == BYTE_LAST_BIT) begin
            res_byte_valid  = 1'b1;
            res_index       = bit_count[COUNT_W-1:3];
            res_byte        = shifted;
            byte_shift_next = '0;
            if (res_index != LAST_BYTE) begin
              crc_reg_next = crc8_byte(crc_reg, shifted);
            end else begin
              res_last    = 1'b1;
              active_next = 1'b0;
              if (crc_reg != shifted) begin
                res_status = STATUS_CRC_BAD;
              end else if (more_flag) begin
                res_status = STATUS_MORE;
              end else begin
                res_status = STATUS_OK;
              end
            end
          end else begin
            byte_shift_next = shifted;
          end
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mask_shift <= '0;
      bit_count  <= '0;
      byte_shift <= '0;
      crc_reg    <= '0;
      more_flag  <= 1'b0;
      active     <= 1'b0;
    end else begin
      mask_shift <= mask_shift_next;
      bit_count  <= bit_count_next;
      byte_shift <= byte_shift_next;
      crc_reg    <= crc_reg_next;
      more_flag  <= more_flag_next;
      active     <= active_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_accept && has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept && has_result) begin
      m_tdata <= {1'b0, res_status, res_byte, res_index, res_byte_valid, res_dir};
      m_tlast <= res_last;
    end
  end

  // Checks
  a_ready_after_reset: assert property (@(posedge clk) rst |=> s_tready)
    else $error("s_tready low right after reset");

  a_last_goes_idle: assert property (@(posedge clk) disable iff (rst)
    (s_accept && has_result && res_last) |=> !active)
    else $error("search still active after final result");

  a_status_only_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[14:13] != STATUS_OK) |-> m_tlast)
    else $error("nonzero status on a result that is not last");

  a_byte_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[1]) |-> (m_tdata[12:2] == '0))
    else $error("byte fields set without byte_valid");

  a_idle_no_result: assert property (@(posedge clk) disable iff (rst)
    (s_accept && !active && in_op == OP_BIT) |=> !m_tvalid)
    else $error("result produced for bit pair while idle");

endmodule

`default_nettype wire

// File: tb/owrse_search_checker.sv
// Scoreboard for the 1-Wire SEARCH ROM decision core: follows both streams,
// predicts each result from its own copy of the search state and compares.
// Depends on owrse_pkg (codes, widths, CRC polynomial).
`default_nettype none

module owrse_search_checker (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             s_tvalid,
  input  wire                             s_tready,
  // s_tdata: [7:0] branch_mask, [8] id_bit, [9] complement_bit
  input  wire [owrse_pkg::IN_DATA_W-1:0]  s_tdata,
  // s_tuser: [0] operation
  input  wire                             s_tuser,
  input  wire                             m_tvalid,
  input  wire                             m_tready,
  // m_tdata: [0] direction_bit, [1] byte_valid, [4:2] byte_index,
  //          [12:5] id_byte, [14:13] status
  input  wire [owrse_pkg::OUT_DATA_W-1:0] m_tdata,
  input  wire                             m_tlast,
  output int                              fail_count,
  output int                              pending,
  output int                              results_checked,
  output logic [3:0]                      statuses_seen
);

  import owrse_pkg::*;

  typedef struct packed {
    logic                dir;
    logic                byte_valid;
    logic [INDEX_W-1:0]  index;
    logic [BYTE_W-1:0]   id_byte;
    logic                last;
    logic [STATUS_W-1:0] status;
  } search_result_t;

  search_result_t search_results_due[$];
  search_result_t oldest;

  // Predicted search state
  logic [MASK_W-1:0]  branch_left;
  logic [COUNT_W-1:0] bits_done;
  logic [BYTE_W-1:0]  byte_acc;
  logic [7:0]         crc_acc;
  logic               more_marked;
  logic               searching;

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // One accepted item: update the search state, queue the result it causes
  task automatic predict_search_step(input logic op, input logic [MASK_W-1:0] mask,
                                     input logic idb, input logic cmp);
    search_result_t r;
    logic           dir;
    logic           fb;
    r = '0;
    if (op == OP_START) begin
      branch_left = mask;
      bits_done   = '0;
      byte_acc    = '0;
      crc_acc     = '0;
      more_marked = 1'b0;
      searching   = 1'b1;
    end else if (searching) begin
      if (idb && cmp) begin
        // no device answered: abort
        r.last    = 1'b1;
        r.status  = STATUS_BOTH_ONE;
        searching = 1'b0;
      end else begin
        if (idb != cmp) begin
          dir = idb;
        end else begin
          // discrepancy: next branch choice, zeros once exhausted
          dir         = branch_left[0];
          branch_left = branch_left >> 1;
          if (!dir) begin
            more_marked = 1'b1;
          end
        end
        r.dir    = dir;
        byte_acc = {dir, byte_acc[BYTE_W-1:1]};
        // serial CRC over the first 56 ID bits
        if (bits_done < 56) begin
          fb      = crc_acc[0] ^ dir;
          crc_acc = crc_acc >> 1;
          if (fb) begin
            crc_acc = crc_acc ^ CRC_POLY;
          end
        end
        if (bits_done[2:0] == BYTE_LAST_BIT) begin
          r.byte_valid = 1'b1;
          r.index      = bits_done[5:3];
          r.id_byte    = byte_acc;
          if (bits_done[5:3] == LAST_BYTE) begin
            r.last    = 1'b1;
            searching = 1'b0;
            if (crc_acc != byte_acc) begin
              r.status = STATUS_CRC_BAD;
            end else if (more_marked) begin
              r.status = STATUS_MORE;
            end else begin
              r.status = STATUS_OK;
            end
          end
          byte_acc = '0;
        end
        bits_done = bits_done + COUNT_W'(1);
      end
      search_results_due.push_back(r);
    end
  endtask

  // Compare leaving results first, then predict from the accepted item
  always @(posedge clk) begin
    if (rst) begin
      search_results_due.delete();
      branch_left     = '0;
      bits_done       = '0;
      byte_acc        = '0;
      crc_acc         = '0;
      more_marked     = 1'b0;
      searching       = 1'b0;
      fail_count      = 0;
      results_checked = 0;
      statuses_seen   = '0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_checked++;
        if (search_results_due.size() == 0) begin
          fail_count++;
          $display("%0t: result with none expected: expected nothing, got m_tdata %h last %b",
                   $time, m_tdata, m_tlast);
        end else begin
          oldest = search_results_due.pop_front();
          check_field("direction_bit", int'(oldest.dir), int'(m_tdata[0]));
          check_field("byte_valid", int'(oldest.byte_valid), int'(m_tdata[1]));
          check_field("byte_index", int'(oldest.index), int'(m_tdata[4:2]));
          check_field("id_byte", int'(oldest.id_byte), int'(m_tdata[12:5]));
          check_field("status", int'(oldest.status), int'(m_tdata[14:13]));
          check_field("last", int'(oldest.last), int'(m_tlast));
          if (oldest.last) begin
            statuses_seen[oldest.status] = 1'b1;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        predict_search_step(s_tuser, s_tdata[7:0], s_tdata[8], s_tdata[9]);
      end
    end
    pending = search_results_due.size();
  end

endmodule

`default_nettype wire

// File: tb/tb_one_wire_rom_search_engine.sv
// Testbench top for the 1-Wire SEARCH ROM decision core: drives search
// sequences and receiver stalls, and reports the verdict of the scoreboard.
// Depends on owrse_pkg, one_wire_rom_search_engine and owrse_search_checker.
`default_nettype none

module tb_one_wire_rom_search_engine;
  import owrse_pkg::*;

  localparam int SEARCH_ITEMS = 1200;
  localparam int QUIET_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 16;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;

  int         fail_count;
  int         pending;
  int         results_checked;
  logic [3:0] statuses_seen;
  int         quiet_cycles = 0;
  int         items_sent;
  bit         tx_idle_en;
  bit         rx_idle_en;
  bit         hold_go;

  one_wire_rom_search_engine dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  owrse_search_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tuser         (s_tuser),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tlast         (m_tlast),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_checked (results_checked),
    .statuses_seen   (statuses_seen)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Result side: random stalls, plus one long hold-off on request
  initial begin : rx_side
    int hold_left;
    hold_left = 0;
    m_tready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go) begin
        hold_go   = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= !rx_idle_en || ($urandom_range(99) >= 32);
      end
    end
  end

  // Watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("tb_one_wire_rom_search_engine NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one item after a random gap; returns at the falling edge after acceptance
  task automatic send_item(input logic op, input logic [7:0] mask,
                           input logic idb, input logic cmp);
    if (tx_idle_en) begin
      while ($urandom_range(99) < 32) begin
        s_tvalid <= 1'b0;
        @(negedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {6'b0, cmp, idb, mask};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Well-formed search: start plus 64 pairs over a random ID whose CRC byte
  // is right unless corrupted; may end early on both-ones or a new start.
  task automatic run_search(input logic [7:0] mask, input int disc_pct,
                            input bit bad_crc, input int abort_at,
                            input int restart_at);
    logic [63:0] id_bits;
    logic [63:0] disc_bits;
    logic [7:0]  mask_left;
    logic [7:0]  crc;
    mask_left = mask;
    for (int i = 0; i < 56; i++) begin
      disc_bits[i] = ($urandom_range(99) < disc_pct);
      if (disc_bits[i]) begin
        id_bits[i] = mask_left[0];
        mask_left  = mask_left >> 1;
      end else begin
        id_bits[i] = 1'($urandom_range(1));
      end
    end
    crc = '0;
    for (int b = 0; b < 7; b++) begin
      crc = crc8_byte(crc, id_bits[b*8 +: 8]);
    end
    if (bad_crc) begin
      crc = crc ^ (8'd1 << $urandom_range(7));
    end
    // CRC byte: a discrepancy only where the branch choice gives the wanted bit
    for (int i = 56; i < 64; i++) begin
      id_bits[i]   = crc[i-56];
      disc_bits[i] = (mask_left[0] == crc[i-56]) && ($urandom_range(99) < disc_pct);
      if (disc_bits[i]) begin
        mask_left = mask_left >> 1;
      end
    end
    send_item(OP_START, mask, 1'($urandom_range(1)), 1'($urandom_range(1)));
    items_sent++;
    for (int i = 0; i < 64; i++) begin
      if (i == restart_at) begin
        return;
      end
      if (i == abort_at) begin
        send_item(OP_BIT, 8'($urandom_range(255)), 1'b1, 1'b1);
        items_sent++;
        return;
      end
      if (disc_bits[i]) begin
        send_item(OP_BIT, 8'($urandom_range(255)), 1'b0, 1'b0);
      end else begin
        send_item(OP_BIT, 8'($urandom_range(255)), id_bits[i], !id_bits[i]);
      end
      items_sent++;
    end
  endtask

  initial begin : stimulus
    logic [7:0] mask;
    int         disc_pct;
    int         pick;
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = 1'b0;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    hold_go    = 1'b0;
    items_sent = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Bit pairs while idle are dropped
    send_item(OP_BIT, 8'h00, 1'b1, 1'b0);
    send_item(OP_BIT, 8'hFF, 1'b1, 1'b1);
    // Plain bits and discrepancies on an all-ones mask
    send_item(OP_START, 8'hFF, 1'b0, 1'b0);
    send_item(OP_BIT, 8'h00, 1'b1, 1'b0);
    send_item(OP_BIT, 8'h00, 1'b0, 1'b1);
    send_item(OP_BIT, 8'h00, 1'b0, 1'b0);
    send_item(OP_BIT, 8'h00, 1'b0, 1'b0);
    // Restart while active, zero choice marks more, then both ones aborts
    send_item(OP_START, 8'h00, 1'b1, 1'b1);
    send_item(OP_BIT, 8'hFF, 1'b0, 1'b0);
    send_item(OP_BIT, 8'hFF, 1'b1, 1'b0);
    send_item(OP_BIT, 8'hFF, 1'b1, 1'b1);
    send_item(OP_BIT, 8'hFF, 1'b0, 1'b0);
    // First byte completes, then the search is abandoned
    send_item(OP_START, 8'hA5, 1'b0, 1'b0);
    for (int i = 0; i < 8; i++) begin
      if (i == 3 || i == 4) begin
        send_item(OP_BIT, 8'h00, i == 3, i == 4);
      end else begin
        send_item(OP_BIT, 8'h00, 1'b0, 1'b0);
      end
    end
    send_item(OP_START, 8'h5A, 1'b1, 1'b0);

    // Receiver holds off while the first random searches keep coming
    hold_go = 1'b1;
    while (items_sent < SEARCH_ITEMS) begin
      // no idling on either side for a stretch
      tx_idle_en = !(items_sent >= 400 && items_sent < 650);
      rx_idle_en = tx_idle_en;
      pick = $urandom_range(9);
      mask = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom_range(255));
      pick = $urandom_range(4);
      disc_pct = (pick < 2) ? 0 : (pick == 2) ? 5 : (pick == 3) ? 15 : 50;
      run_search(mask, disc_pct, $urandom_range(3) == 0,
                 ($urandom_range(7) == 0) ? int'($urandom_range(63)) : -1,
                 ($urandom_range(9) == 0) ? int'($urandom_range(63)) : -1);
      // occasional noise between searches
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          send_item($urandom_range(7) != 0, 8'($urandom_range(255)),
                    1'($urandom_range(1)), 1'($urandom_range(1)));
        end
      end
    end
    s_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d search items, checked %0d results;", items_sent, results_checked);
    $display("closing statuses seen (crc bad, both ones, more, ok): %b", statuses_seen);
    if (fail_count == 0) begin
      $display("tb_one_wire_rom_search_engine OK");
    end else begin
      $display("tb_one_wire_rom_search_engine NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
